// File: rtl/core/rcpd_pkg.sv
// Shared constants, register indexes and types of the RC PPM command decoder.
`default_nettype none
package rcpd_pkg;

  localparam int NUM_CHANNELS_DEF = 8;

  // Pulse width limits in microseconds
  localparam logic [10:0] WIDTH_MIN = 11'd900;
  localparam logic [10:0] WIDTH_MAX = 11'd2000;
  localparam logic [10:0] WIDTH_MID = 11'd1500;

  // Register reset values
  localparam logic [15:0] SYNC_GAP_RST = 16'd10000;
  localparam logic [15:0] LAT_GAIN_RST = 16'd32768;
  localparam logic [15:0] FWD_GAIN_RST = 16'd32768;
  localparam logic [15:0] YAW_GAIN_RST = 16'd16384;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_SYNC_GAP = 2'd0;
  localparam logic [1:0] REG_LAT_GAIN = 2'd1;
  localparam logic [1:0] REG_FWD_GAIN = 2'd2;
  localparam logic [1:0] REG_YAW_GAIN = 2'd3;

  // Shared multiplier
  localparam int MUL_W  = 26;
  localparam int PROD_W = 2 * MUL_W;

  // floor(x * 32768 / 1100) = (x * THR_RECIP) >> THR_SHIFT for x <= 1100
  localparam int THR_SHIFT = 21;
  localparam longint unsigned THR_RECIP_L = ((64'd1 << 36) + 64'd1099) / 64'd1100;
  localparam logic [MUL_W-1:0] THR_RECIP = MUL_W'(THR_RECIP_L);

  // floor(m / 1500) = (m * CMD_RECIP) >> CMD_SHIFT for m < 2^25
  localparam int CMD_SHIFT = 36;
  localparam longint unsigned CMD_RECIP_L = ((64'd1 << 36) + 64'd1499) / 64'd1500;
  localparam logic [MUL_W-1:0] CMD_RECIP = MUL_W'(CMD_RECIP_L);

  // Command slots worked in turn
  localparam logic [1:0] CMD_LAT = 2'd0;
  localparam logic [1:0] CMD_FWD = 2'd1;
  localparam logic [1:0] CMD_YAW = 2'd2;

  typedef struct packed {
    logic [15:0] sync_gap;
    logic [15:0] lat_gain;
    logic [15:0] fwd_gain;
    logic [15:0] yaw_gain;
  } cfg_regs_t;

endpackage
`default_nettype wire

// File: rtl/core/rcpd_mul.sv
// Shared unsigned multiplier with registered product.
`default_nettype none
module rcpd_mul (
  input  wire logic                        clk,
  input  wire logic [rcpd_pkg::MUL_W-1:0]  op_a,
  input  wire logic [rcpd_pkg::MUL_W-1:0]  op_b,
  output logic      [rcpd_pkg::PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= rcpd_pkg::PROD_W'(op_a) * rcpd_pkg::PROD_W'(op_b);
  end

endmodule
`default_nettype wire

// File: rtl/core/rcpd_cfg.sv
// APB register file holding the sync limit and the three command gains.
`default_nettype none
module rcpd_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [rcpd_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [rcpd_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [rcpd_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output rcpd_pkg::cfg_regs_t                      regs
);

  rcpd_pkg::cfg_regs_t regs_r;
  logic [1:0]          reg_idx;
  logic                wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign regs    = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.sync_gap <= rcpd_pkg::SYNC_GAP_RST;
      regs_r.lat_gain <= rcpd_pkg::LAT_GAIN_RST;
      regs_r.fwd_gain <= rcpd_pkg::FWD_GAIN_RST;
      regs_r.yaw_gain <= rcpd_pkg::YAW_GAIN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        rcpd_pkg::REG_SYNC_GAP: regs_r.sync_gap <= pwdata[15:0];
        rcpd_pkg::REG_LAT_GAIN: regs_r.lat_gain <= pwdata[15:0];
        rcpd_pkg::REG_FWD_GAIN: regs_r.fwd_gain <= pwdata[15:0];
        rcpd_pkg::REG_YAW_GAIN: regs_r.yaw_gain <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rcpd_pkg::REG_SYNC_GAP: prdata = rcpd_pkg::CFG_DATA_W'(regs_r.sync_gap);
      rcpd_pkg::REG_LAT_GAIN: prdata = rcpd_pkg::CFG_DATA_W'(regs_r.lat_gain);
      rcpd_pkg::REG_FWD_GAIN: prdata = rcpd_pkg::CFG_DATA_W'(regs_r.fwd_gain);
      rcpd_pkg::REG_YAW_GAIN: prdata = rcpd_pkg::CFG_DATA_W'(regs_r.yaw_gain);
      default:                prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/ppm_rc_command_decoder.sv
// A stored pulse's result follows the throttle step, three command rounds and
// the output step; a sync or overrun edge is absorbed in the accepting cycle
// with no result. One sync edge per cycle while idle; input stalls while a pulse
// is in work. An item's ten products pass one registered multiplier in turn.
// Reset (rst_n, synchronous): slot index and last edge time clear, every channel
// slot returns to 900 us, registers return to their defaults, no result pending.
`default_nettype none
module ppm_rc_command_decoder #(
  parameter int NUM_CHANNELS = rcpd_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input items
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [15:0]                         in_edge_time,
  // result items
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [14:0]                         out_throttle,
  output logic signed [15:0]                       out_lateral,
  output logic signed [15:0]                       out_forward,
  output logic signed [15:0]                       out_yaw,
  output logic      [2:0]                          out_stored_channel,
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [rcpd_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [rcpd_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [rcpd_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  localparam int SLOT_W = $clog2(NUM_CHANNELS + 1);
  localparam int CH_W   = $clog2(NUM_CHANNELS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_THR  = 3'd1;
  localparam logic [2:0] ST_A    = 3'd2;
  localparam logic [2:0] ST_B    = 3'd3;
  localparam logic [2:0] ST_Q    = 3'd4;
  localparam logic [2:0] ST_R    = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  rcpd_pkg::cfg_regs_t cfg;

  rcpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (cfg)
  );

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          k_r;
  logic [15:0]         prev_r;
  logic [SLOT_W-1:0]   slot_idx_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [10:0]         chan_r [NUM_CHANNELS];
  logic [14:0]         thr_r;
  logic signed [15:0]  lat_r, fwd_r, yaw_r;
  logic                out_valid_r;
  logic [14:0]         out_thr_r;
  logic signed [15:0]  out_lat_r, out_fwd_r, out_yaw_r;
  logic [2:0]          out_ch_r;

  logic                       in_acc;
  logic [15:0]                gap;
  logic                       frame_restart;
  logic [10:0]                width_clamped;
  logic [10:0]                w_sel;
  logic [15:0]                gain_sel;
  logic                       neg_sel;
  logic [10:0]                mag_sel;
  logic [14:0]                thr_sat;
  logic [14:0]                thr_cur;
  logic [14:0]                q_mag;
  logic signed [15:0]         q_signed;
  logic                       out_free;
  logic [rcpd_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [rcpd_pkg::PROD_W-1:0] prod_r;

  rcpd_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;

  assign gap           = in_edge_time - prev_r;
  assign frame_restart = (gap > cfg.sync_gap) || (slot_idx_r >= SLOT_W'(NUM_CHANNELS));

  always_comb begin
    if (gap > 16'(rcpd_pkg::WIDTH_MAX)) begin
      width_clamped = rcpd_pkg::WIDTH_MAX;
    end else if (gap < 16'(rcpd_pkg::WIDTH_MIN)) begin
      width_clamped = rcpd_pkg::WIDTH_MIN;
    end else begin
      width_clamped = gap[10:0];
    end
  end

  // Channel and gain of the command being worked
  always_comb begin
    case (k_r)
      rcpd_pkg::CMD_LAT: begin
        w_sel    = chan_r[0];
        gain_sel = cfg.lat_gain;
      end
      rcpd_pkg::CMD_FWD: begin
        w_sel    = chan_r[1];
        gain_sel = cfg.fwd_gain;
      end
      default: begin
        w_sel    = chan_r[3];
        gain_sel = cfg.yaw_gain;
      end
    endcase
  end

  assign neg_sel = (w_sel < rcpd_pkg::WIDTH_MID);
  assign mag_sel = neg_sel ? (rcpd_pkg::WIDTH_MID - w_sel) : (w_sel - rcpd_pkg::WIDTH_MID);

  // Throttle reaches 32768 only at full stick; hold it at 32767
  assign thr_sat = prod_r[rcpd_pkg::THR_SHIFT+15] ? 15'h7fff :
                   prod_r[rcpd_pkg::THR_SHIFT+14:rcpd_pkg::THR_SHIFT];
  assign thr_cur = (k_r == rcpd_pkg::CMD_LAT) ? thr_sat : thr_r;

  // Magnitude stays below 13107, so the signed result never needs clipping
  assign q_mag    = prod_r[rcpd_pkg::CMD_SHIFT+14:rcpd_pkg::CMD_SHIFT];
  assign q_signed = (neg_sel ^ (k_r == rcpd_pkg::CMD_FWD)) ? -$signed({1'b0, q_mag})
                                                           : $signed({1'b0, q_mag});

  always_comb begin
    unique case (state_r)
      ST_THR: begin
        mul_a = rcpd_pkg::MUL_W'(chan_r[2] - rcpd_pkg::WIDTH_MIN);
        mul_b = rcpd_pkg::THR_RECIP;
      end
      ST_A: begin
        mul_a = rcpd_pkg::MUL_W'(thr_cur);
        mul_b = rcpd_pkg::MUL_W'(mag_sel);
      end
      ST_B: begin
        mul_a = rcpd_pkg::MUL_W'(prod_r[24:0]);
        mul_b = rcpd_pkg::MUL_W'(gain_sel);
      end
      ST_Q: begin
        // drop the Q0.16 gain fraction, then divide by 1500
        mul_a = rcpd_pkg::MUL_W'(prod_r[40:16]);
        mul_b = rcpd_pkg::CMD_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && !frame_restart) state_nxt = ST_THR;
      ST_THR:  state_nxt = ST_A;
      ST_A:    state_nxt = ST_B;
      ST_B:    state_nxt = ST_Q;
      ST_Q:    state_nxt = ST_R;
      ST_R:    state_nxt = (k_r == rcpd_pkg::CMD_YAW) ? ST_OUT : ST_A;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= rcpd_pkg::CMD_LAT;
      prev_r      <= '0;
      slot_idx_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_r[i] <= rcpd_pkg::WIDTH_MIN;
      end
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        prev_r <= in_edge_time;
        if (frame_restart) begin
          slot_idx_r <= '0;
        end else begin
          chan_r[slot_idx_r[CH_W-1:0]] <= width_clamped;
          slot_idx_r <= slot_idx_r + 1'b1;
        end
      end
      if (state_r == ST_THR) begin
        k_r <= rcpd_pkg::CMD_LAT;
      end else if (state_r == ST_R && k_r != rcpd_pkg::CMD_YAW) begin
        k_r <= k_r + 1'b1;
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r <= slot_idx_r;
    end
    if (state_r == ST_A && k_r == rcpd_pkg::CMD_LAT) begin
      thr_r <= thr_sat;
    end
    if (state_r == ST_R) begin
      case (k_r)
        rcpd_pkg::CMD_LAT: lat_r <= q_signed;
        rcpd_pkg::CMD_FWD: fwd_r <= q_signed;
        default:           yaw_r <= q_signed;
      endcase
    end
    if (state_r == ST_OUT && out_free) begin
      out_thr_r <= thr_r;
      out_lat_r <= lat_r;
      out_fwd_r <= fwd_r;
      out_yaw_r <= yaw_r;
      out_ch_r  <= 3'(slot_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_throttle       = out_thr_r;
  assign out_lateral        = out_lat_r;
  assign out_forward        = out_fwd_r;
  assign out_yaw            = out_yaw_r;
  assign out_stored_channel = out_ch_r;

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_idx_r <= SLOT_W'(NUM_CHANNELS))
    else $error("slot index beyond channel count");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside the output step");

  a_all_cmds_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (k_r == rcpd_pkg::CMD_YAW))
    else $error("output step reached before all commands worked");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input open while an item is in work");

endmodule
`default_nettype wire
